FILE: hw/rtl/ssmc_pkg.sv
// ----------------------------------------------------------------------------
// ssmc_pkg
// shared types, constants and codes for the servo sweep mode controller
// ----------------------------------------------------------------------------
package ssmc_pkg;

  localparam int POT_BITS    = 12;
  localparam int DWELL_W     = 16;
  localparam int STEP_W      = 4;
  localparam int ANGLE_W     = 8;
  localparam int ANGLE_ST_W  = 9;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ANGLE_MAX   = 180;

  localparam int IN_FIELDS_W  = 3 + POT_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = MODE_W + ANGLE_W + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UP_DWELL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_DWELL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_DWELL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd4;

  // register reset values
  localparam logic [DWELL_W-1:0] UP_DWELL_RST   = 16'd100;
  localparam logic [DWELL_W-1:0] DOWN_DWELL_RST = 16'd200;
  localparam logic [DWELL_W-1:0] END_DWELL_RST  = 16'd1000;
  localparam logic [DWELL_W-1:0] POLL_RST       = 16'd100;
  localparam logic [STEP_W-1:0]  STEP_RST       = 4'd2;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_WAITING = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MANUAL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_AUTO    = 2'd3;

  typedef struct packed {
    logic [DWELL_W-1:0] up_dwell_ms;
    logic [DWELL_W-1:0] down_dwell_ms;
    logic [DWELL_W-1:0] end_dwell_ms;
    logic [DWELL_W-1:0] poll_ms;
    logic [STEP_W-1:0]  step_degrees;
  } cfg_t;

  // lowest bit first: loop, manual, shutdown, pot
  typedef struct packed {
    logic [POT_BITS-1:0] pot_sample;
    logic                shutdown_button_level;
    logic                manual_button_level;
    logic                loop_button_level;
  } in_item_t;

  // lowest bit first: mode, servo_angle, direction, angle_written
  typedef struct packed {
    logic               angle_written;
    logic               direction;
    logic [ANGLE_W-1:0] servo_angle;
    logic [MODE_W-1:0]  mode;
  } out_item_t;

endpackage

FILE: hw/rtl/servo_sweep_mode_controller_core.sv
// ----------------------------------------------------------------------------
// servo_sweep_mode_controller_core
// millisecond-tick servo sweep controller with pause, manual and auto modes
// ----------------------------------------------------------------------------
// Each request on the input stream is one millisecond tick with three button
// levels and a potentiometer sample; each tick gives exactly one result with
// the mode, the clamped servo angle, the sweep direction and a flag that marks
// a newly written angle. The block takes one request per clock cycle while
// its result register is free or being taken. The path is one input
// register, combinational iteration logic and one output register: the result
// is loaded into the output register when its request advances. While a
// result waits for m_axis_tready, the input register still takes one more
// request before the input side stalls. Configuration is accepted in every
// cycle and should be written only while the block is idle.
module servo_sweep_mode_controller_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // loop_button_level, manual_button_level, shutdown_button_level, pot_sample
  input  logic [ssmc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // mode, servo_angle, direction, angle_written
  output logic [ssmc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ssmc_pkg::*;

  cfg_t      cfg;
  logic      in_valid;
  in_item_t  in_item;
  logic      advance;
  out_item_t res;
  out_item_t out_item;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_item};

  ssmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssmc_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (in_item),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= s_axis_tdata[IN_FIELDS_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

endmodule

FILE: hw/rtl/ssmc_cfg.sv
// ----------------------------------------------------------------------------
// ssmc_cfg
// configuration register file with its write channel
// ----------------------------------------------------------------------------
module ssmc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssmc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ssmc_pkg::cfg_t                    cfg
);
  import ssmc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.up_dwell_ms   <= UP_DWELL_RST;
      cfg.down_dwell_ms <= DOWN_DWELL_RST;
      cfg.end_dwell_ms  <= END_DWELL_RST;
      cfg.poll_ms       <= POLL_RST;
      cfg.step_degrees  <= STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UP_DWELL:   cfg.up_dwell_ms   <= cfg_data[DWELL_W-1:0];
        REG_DOWN_DWELL: cfg.down_dwell_ms <= cfg_data[DWELL_W-1:0];
        REG_END_DWELL:  cfg.end_dwell_ms  <= cfg_data[DWELL_W-1:0];
        REG_POLL:       cfg.poll_ms       <= cfg_data[DWELL_W-1:0];
        REG_STEP:       cfg.step_degrees  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ssmc_iter.sv
// ----------------------------------------------------------------------------
// ssmc_iter
// controller state and the per-tick iteration logic
// ----------------------------------------------------------------------------
module ssmc_iter (
  input  logic                 clk,
  input  logic                 rst,
  input  ssmc_pkg::cfg_t       cfg,
  input  logic                 advance,
  input  ssmc_pkg::in_item_t   item,
  output ssmc_pkg::out_item_t  res
);
  import ssmc_pkg::*;

  localparam int PROD_W = POT_BITS + ANGLE_W;

  function automatic logic [DWELL_W-1:0] to_wait(input logic [DWELL_W-1:0] d);
    to_wait = (d == '0) ? '0 : d - DWELL_W'(1);
  endfunction

  logic [DWELL_W-1:0]           wait_count, wait_count_next;
  logic signed [ANGLE_ST_W-1:0] angle, angle_next;
  logic                         sweep_negative, sweep_negative_next;
  logic                         paused_flag, paused_flag_next;
  logic                         manual_flag, manual_flag_next;
  logic                         auto_flag, auto_flag_next;
  logic                         mode_chosen, mode_chosen_next;
  logic [2:0]                   last_levels, last_levels_next;

  logic [PROD_W-1:0]            prod;
  logic [ANGLE_W-1:0]           quot;
  logic [POT_BITS:0]            rem;
  logic [ANGLE_W-1:0]           manual_angle;
  logic signed [ANGLE_ST_W-1:0] stepped;
  logic                         written;
  logic [MODE_W-1:0]            mode;
  logic [ANGLE_W-1:0]           clamped;

  // pot * 180 / (2^n - 1): quotient by 2^n is low by at most one
  always_comb begin
    prod = PROD_W'(item.pot_sample) * PROD_W'(ANGLE_MAX);
    quot = prod[PROD_W-1:POT_BITS];
    rem  = {1'b0, prod[POT_BITS-1:0]} + (POT_BITS+1)'(quot);
    manual_angle = quot + ANGLE_W'(rem >= (POT_BITS+1)'((1 << POT_BITS) - 1));
  end

  always_comb begin
    stepped = sweep_negative ? angle - $signed({5'b0, cfg.step_degrees})
                             : angle + $signed({5'b0, cfg.step_degrees});
  end

  always_comb begin
    wait_count_next     = wait_count;
    angle_next          = angle;
    sweep_negative_next = sweep_negative;
    paused_flag_next    = paused_flag;
    manual_flag_next    = manual_flag;
    auto_flag_next      = auto_flag;
    mode_chosen_next    = mode_chosen;
    last_levels_next    = last_levels;
    written             = 1'b0;
    if (wait_count != '0) begin
      wait_count_next = wait_count - DWELL_W'(1);
    end else begin
      // order: shutdown, manual, loop
      if (item.shutdown_button_level != last_levels[0]) begin
        paused_flag_next = 1'b1;
        auto_flag_next   = 1'b0;
        mode_chosen_next = 1'b1;
      end
      if (item.manual_button_level != last_levels[1]) begin
        paused_flag_next = 1'b0;
        manual_flag_next = 1'b1;
        auto_flag_next   = 1'b0;
        mode_chosen_next = 1'b1;
      end
      if (item.loop_button_level != last_levels[2]) begin
        paused_flag_next = 1'b0;
        manual_flag_next = 1'b0;
        auto_flag_next   = 1'b1;
        mode_chosen_next = 1'b1;
      end
      last_levels_next = {item.loop_button_level, item.manual_button_level,
                          item.shutdown_button_level};
      if (mode_chosen_next && !paused_flag_next && manual_flag_next) begin
        angle_next      = $signed({1'b0, manual_angle});
        written         = 1'b1;
        wait_count_next = to_wait(cfg.poll_ms);
      end else if (mode_chosen_next && !paused_flag_next && auto_flag_next) begin
        angle_next = stepped;
        written    = 1'b1;
        if (stepped >= 9'sd180 || stepped <= 9'sd0) begin
          sweep_negative_next = !sweep_negative;
          wait_count_next     = to_wait(cfg.end_dwell_ms);
        end else if (!sweep_negative) begin
          wait_count_next = to_wait(cfg.up_dwell_ms);
        end else begin
          wait_count_next = to_wait(cfg.down_dwell_ms);
        end
      end else begin
        wait_count_next = to_wait(cfg.poll_ms);
      end
    end
  end

  always_comb begin
    if (!mode_chosen_next) begin
      mode = MODE_WAITING;
    end else if (paused_flag_next) begin
      mode = MODE_PAUSED;
    end else if (manual_flag_next) begin
      mode = MODE_MANUAL;
    end else if (auto_flag_next) begin
      mode = MODE_AUTO;
    end else begin
      mode = MODE_PAUSED;
    end
    if (angle_next < 9'sd0) begin
      clamped = '0;
    end else if (angle_next > 9'sd180) begin
      clamped = ANGLE_W'(ANGLE_MAX);
    end else begin
      clamped = angle_next[ANGLE_W-1:0];
    end
    res.mode          = mode;
    res.servo_angle   = clamped;
    res.direction     = sweep_negative_next;
    res.angle_written = written;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_count     <= '0;
      angle          <= '0;
      sweep_negative <= 1'b0;
      paused_flag    <= 1'b0;
      manual_flag    <= 1'b0;
      auto_flag      <= 1'b0;
      mode_chosen    <= 1'b0;
      last_levels    <= '1;
    end else if (advance) begin
      wait_count     <= wait_count_next;
      angle          <= angle_next;
      sweep_negative <= sweep_negative_next;
      paused_flag    <= paused_flag_next;
      manual_flag    <= manual_flag_next;
      auto_flag      <= auto_flag_next;
      mode_chosen    <= mode_chosen_next;
      last_levels    <= last_levels_next;
    end
  end

endmodule

FILE: tb/tb_servo_sweep_mode_controller_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_sweep_mode_controller_core
// self-checking bench for the servo sweep mode controller
// ----------------------------------------------------------------------------
// Feeds millisecond ticks with button levels and pot samples on the input
// stream and checks every result against a tick-by-tick model of the wait
// counter, button edge handling, manual and sweep angle updates. Registers
// are changed between phases while the block is drained. Phases vary dwell
// and poll settings (zero, small, moderate, all ones), the step size
// (zero through fifteen) and the amount of idling on both streams.
// ----------------------------------------------------------------------------
module tb_servo_sweep_mode_controller_core;
  import ssmc_pkg::*;

  localparam int POT_FULL = (1 << POT_BITS) - 1;

  class tick_scoreboard;
    logic [DWELL_W-1:0] up_dwell, down_dwell, end_dwell, poll_period;
    logic [STEP_W-1:0]  step_deg;
    logic [DWELL_W-1:0] wait_left;
    int                 angle_st;
    bit                 sweep_neg, paused, manual, auto_on, chosen;
    bit                 lst_shut, lst_man, lst_loop;
    out_item_t          expected_q[$];
    int                 errors;

    function new();
      up_dwell    = UP_DWELL_RST;
      down_dwell  = DOWN_DWELL_RST;
      end_dwell   = END_DWELL_RST;
      poll_period = POLL_RST;
      step_deg    = STEP_RST;
      wait_left   = '0;
      angle_st    = 0;
      sweep_neg   = 1'b0;
      paused      = 1'b0;
      manual      = 1'b0;
      auto_on     = 1'b0;
      chosen      = 1'b0;
      lst_shut    = 1'b1;
      lst_man     = 1'b1;
      lst_loop    = 1'b1;
      errors      = 0;
    endfunction

    function logic [DWELL_W-1:0] reload(logic [DWELL_W-1:0] d);
      return (d == '0) ? '0 : d - 1'b1;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_UP_DWELL:   up_dwell = val;
        REG_DOWN_DWELL: down_dwell = val;
        REG_END_DWELL:  end_dwell = val;
        REG_POLL:       poll_period = val;
        REG_STEP:       step_deg = val[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(in_item_t it);
      out_item_t o;
      bit wrote;
      wrote = 1'b0;
      if (wait_left != '0) begin
        wait_left = wait_left - 1'b1;
      end else begin
        if (lst_shut != it.shutdown_button_level) begin
          paused = 1'b1;
          auto_on = 1'b0;
          chosen = 1'b1;
        end
        lst_shut = it.shutdown_button_level;
        if (lst_man != it.manual_button_level) begin
          paused = 1'b0;
          manual = 1'b1;
          auto_on = 1'b0;
          chosen = 1'b1;
        end
        lst_man = it.manual_button_level;
        if (lst_loop != it.loop_button_level) begin
          paused = 1'b0;
          manual = 1'b0;
          auto_on = 1'b1;
          chosen = 1'b1;
        end
        lst_loop = it.loop_button_level;

        if (chosen && !paused && manual) begin
          angle_st = (int'(it.pot_sample) * ANGLE_MAX) / POT_FULL;
          wrote = 1'b1;
          wait_left = reload(poll_period);
        end else if (chosen && !paused && auto_on) begin
          angle_st = sweep_neg ? angle_st - int'(step_deg) : angle_st + int'(step_deg);
          wrote = 1'b1;
          if (angle_st >= ANGLE_MAX || angle_st <= 0) begin
            sweep_neg = !sweep_neg;
            wait_left = reload(end_dwell);
          end else if (!sweep_neg) begin
            wait_left = reload(up_dwell);
          end else begin
            wait_left = reload(down_dwell);
          end
        end else begin
          wait_left = reload(poll_period);
        end
      end

      if (!chosen) o.mode = MODE_WAITING;
      else if (paused) o.mode = MODE_PAUSED;
      else if (manual) o.mode = MODE_MANUAL;
      else if (auto_on) o.mode = MODE_AUTO;
      else o.mode = MODE_PAUSED;
      o.servo_angle = (angle_st < 0) ? '0 :
                      (angle_st > ANGLE_MAX) ? ANGLE_W'(ANGLE_MAX) : ANGLE_W'(angle_st);
      o.direction = sweep_neg;
      o.angle_written = wrote;
      expected_q.push_back(o);
    endfunction

    function void report_mismatch(string what, int got, int want);
      errors++;
      $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no tick pending, mode", got.mode, -1);
        return;
      end
      want = expected_q.pop_front();
      if (got.mode !== want.mode)
        report_mismatch("mode", got.mode, want.mode);
      if (got.servo_angle !== want.servo_angle)
        report_mismatch("servo_angle", got.servo_angle, want.servo_angle);
      if (got.direction !== want.direction)
        report_mismatch("direction", got.direction, want.direction);
      if (got.angle_written !== want.angle_written)
        report_mismatch("angle_written", got.angle_written, want.angle_written);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tick_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit lvl_shut = 1'b1, lvl_man = 1'b1, lvl_loop = 1'b1;

  servo_sweep_mode_controller_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_servo_sweep_mode_controller_core failed");
    $finish;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(out_item_t'(m_axis_tdata[OUT_FIELDS_W-1:0]));
  end

  // called at a falling edge; leaves tvalid high for a following request
  task automatic push_tick(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, it};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(it);
    @(negedge clk);
  endtask

  function automatic in_item_t make_tick(input logic [POT_BITS-1:0] pot);
    in_item_t it;
    it.loop_button_level     = lvl_loop;
    it.manual_button_level   = lvl_man;
    it.shutdown_button_level = lvl_shut;
    it.pot_sample            = pot;
    return it;
  endfunction

  task automatic toggle_tick(input bit t_shut, input bit t_man, input bit t_loop,
                             input logic [POT_BITS-1:0] pot);
    lvl_shut ^= t_shut;
    lvl_man  ^= t_man;
    lvl_loop ^= t_loop;
    push_tick(make_tick(pot));
  endtask

  task automatic random_ticks(input int count);
    int r;
    logic [POT_BITS-1:0] pot;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 2) lvl_shut = ~lvl_shut;
      else if (r < 5) lvl_man = ~lvl_man;
      else if (r < 8) lvl_loop = ~lvl_loop;
      else if (r < 10) {lvl_shut, lvl_man, lvl_loop} = 3'($urandom);
      r = $urandom_range(99);
      pot = (r < 15) ? '0 : (r < 30) ? POT_BITS'(POT_FULL) : POT_BITS'($urandom);
      push_tick(make_tick(pot));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // leaves cfg_valid high for a following request
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] up, input logic [CFG_DATA_W-1:0] dn,
                          input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] pl,
                          input logic [CFG_DATA_W-1:0] st);
    write_reg(REG_UP_DWELL, up);
    write_reg(REG_DOWN_DWELL, dn);
    write_reg(REG_END_DWELL, en);
    write_reg(REG_POLL, pl);
    write_reg(REG_STEP, st);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] st;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values
    random_ticks(300);
    wait_idle();

    // every tick iterates; zero dwell acts as one
    set_regs(16'd1, 16'd0, 16'd1, 16'd0, 16'd15);
    toggle_tick(0, 0, 0, '0);
    toggle_tick(0, 1, 0, 12'd4095);
    toggle_tick(0, 0, 0, 12'd0);
    toggle_tick(0, 0, 0, 12'd2048);
    toggle_tick(1, 0, 0, 12'd4095);
    toggle_tick(0, 0, 0, 12'd4095);
    toggle_tick(0, 1, 0, 12'd1);
    toggle_tick(0, 0, 0, 12'd3981);
    toggle_tick(0, 0, 1, 12'd0);
    toggle_tick(0, 0, 0, 12'd0);
    toggle_tick(0, 0, 0, 12'd0);
    toggle_tick(0, 0, 0, 12'd0);
    toggle_tick(1, 0, 0, 12'd0);
    toggle_tick(0, 0, 0, 12'd0);
    toggle_tick(0, 0, 1, 12'd0);
    toggle_tick(1, 1, 1, 12'd0);
    toggle_tick(1, 1, 0, 12'd3000);
    toggle_tick(0, 1, 0, 12'd250);
    toggle_tick(0, 0, 1, 12'd4095);
    toggle_tick(0, 0, 0, 12'd0);
    toggle_tick(0, 0, 0, 12'd0);
    toggle_tick(1, 1, 1, 12'd1234);
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      case (ph % 4)
        1: tx_idle_pct = 71;
        2: rx_stall_pct = 71;
        3: begin
          tx_idle_pct  = 7;
          rx_stall_pct = 7;
        end
        default: ;
      endcase
      st = (ph == 0) ? 16'd0 : (ph == 1) ? 16'd10 : (ph == 2) ? 16'hFFF3 :
           CFG_DATA_W'($urandom_range(1, 15));
      if (ph == 3) begin
        for (int i = int'(REG_STEP) + 1; i < (1 << CFG_IDX_W); i++)
          write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
      end
      if (ph == 5)
        set_regs(16'd7, 16'd13, 16'd29, 16'd41, st);
      else
        set_regs(CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 3)),
                 CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 3)), st);
      random_ticks(100);
    end

    wait_idle();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_ticks(60);

    wait_idle();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_servo_sweep_mode_controller_core passed");
    end else begin
      $display("tb_servo_sweep_mode_controller_core failed");
    end
    $finish;
  end

endmodule
